// ----- rtl/core/tfapf_pkg.sv -----
// ----------------------------------------------------------------------------
// tfapf_pkg
// Shared types and constants for the Ethernet/IPv4/TCP address and port
// filter.
// ----------------------------------------------------------------------------
package tfapf_pkg;

  localparam int unsigned NumRegs       = 8;
  localparam int unsigned FilterEntries = 8;
  localparam int unsigned CfgIdxW       = 4;
  localparam int unsigned EntryW        = 49;
  localparam int unsigned PosW          = 12;
  localparam int unsigned TcpStartW     = 7;

  localparam logic [PosW-1:0] PosMax       = 12'd4095;
  localparam logic [PosW-1:0] PosEthTypeHi = 12'd12;
  localparam logic [PosW-1:0] PosEthTypeLo = 12'd13;
  localparam logic [PosW-1:0] PosIhl       = 12'd14;
  localparam logic [PosW-1:0] PosTotLenHi  = 12'd16;
  localparam logic [PosW-1:0] PosTotLenLo  = 12'd17;
  localparam logic [PosW-1:0] PosProto     = 12'd23;
  localparam logic [PosW-1:0] PosSaddrLo   = 12'd26;
  localparam logic [PosW-1:0] PosSaddrHi   = 12'd29;
  localparam logic [PosW-1:0] PosDaddrLo   = 12'd30;
  localparam logic [PosW-1:0] PosDaddrHi   = 12'd33;

  localparam logic [PosW-1:0] OffSportHi   = 12'd0;
  localparam logic [PosW-1:0] OffSportLo   = 12'd1;
  localparam logic [PosW-1:0] OffDportHi   = 12'd2;
  localparam logic [PosW-1:0] OffDportLo   = 12'd3;
  localparam logic [PosW-1:0] OffDataOff   = 12'd12;

  localparam logic [TcpStartW-1:0] EthHdrLen = 7'd14;
  localparam logic [TcpStartW-1:0] TcpHdrMin = 7'd20;
  localparam logic [TcpStartW-1:0] MinNeed   = 7'd34;
  localparam logic [PosW-1:0]      LenEth    = 12'd14;
  localparam logic [PosW-1:0]      LenProto  = 12'd24;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'h06;
  localparam logic [7:0]  LowNibble     = 8'h0F;
  localparam logic [7:0]  HighNibble    = 8'hF0;

  typedef enum logic [2:0] {
    RsnMatch   = 3'd0,
    RsnNotIpv4 = 3'd1,
    RsnNotTcp  = 3'd2,
    RsnEmpty   = 3'd3,
    RsnNoHit   = 3'd4,
    RsnTrunc   = 3'd5
  } reason_e;

  typedef struct packed {
    logic        vld;
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

  typedef entry_t [NumRegs-1:0] entry_arr_t;

  typedef struct packed {
    logic [PosW-1:0] len;
    logic [15:0]     ether_type;
    logic [3:0]      ihl;
    logic [15:0]     total_len;
    logic [7:0]      proto;
    logic [31:0]     saddr;
    logic [31:0]     daddr;
    logic [15:0]     sport;
    logic [15:0]     dport;
    logic [3:0]      thw;
  } hdr_t;

endpackage

// ----- rtl/core/tfapf_capture.sv -----
// ----------------------------------------------------------------------------
// tfapf_capture
// Byte position counter and header field capture. Presents the fields as
// they stand after the current byte; clears after the final byte.
// ----------------------------------------------------------------------------
module tfapf_capture (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output tfapf_pkg::hdr_t   hdr_o
);

  tfapf_pkg::hdr_t hdr_q, hdr_d;

  logic [tfapf_pkg::TcpStartW-1:0] tcp_start;
  logic [tfapf_pkg::PosW-1:0]      tcp_start_w;
  logic [tfapf_pkg::PosW-1:0]      off;
  logic [tfapf_pkg::PosW-1:0]      pos;
  logic [7:0]                      nib_lo, nib_hi;

  always_comb begin
    pos    = hdr_q.len;
    hdr_d  = hdr_q;
    nib_lo = byte_i & tfapf_pkg::LowNibble;
    nib_hi = byte_i & tfapf_pkg::HighNibble;

    if (pos == tfapf_pkg::PosEthTypeHi) hdr_d.ether_type = {byte_i, 8'h00};
    if (pos == tfapf_pkg::PosEthTypeLo) hdr_d.ether_type = {hdr_q.ether_type[15:8], byte_i};
    if (pos == tfapf_pkg::PosIhl)       hdr_d.ihl = nib_lo[3:0];
    if (pos == tfapf_pkg::PosTotLenHi)  hdr_d.total_len = {byte_i, 8'h00};
    if (pos == tfapf_pkg::PosTotLenLo)  hdr_d.total_len = {hdr_q.total_len[15:8], byte_i};
    if (pos == tfapf_pkg::PosProto)     hdr_d.proto = byte_i;
    if (pos inside {[tfapf_pkg::PosSaddrLo:tfapf_pkg::PosSaddrHi]}) begin
      hdr_d.saddr = {hdr_q.saddr[23:0], byte_i};
    end
    if (pos inside {[tfapf_pkg::PosDaddrLo:tfapf_pkg::PosDaddrHi]}) begin
      hdr_d.daddr = {hdr_q.daddr[23:0], byte_i};
    end

    // TCP header start uses the IHL taken from this very byte
    tcp_start   = tfapf_pkg::EthHdrLen + {1'b0, hdr_d.ihl, 2'b00};
    tcp_start_w = {{(tfapf_pkg::PosW-tfapf_pkg::TcpStartW){1'b0}}, tcp_start};
    off         = pos - tcp_start_w;
    if (pos >= tcp_start_w) begin
      case (off)
        tfapf_pkg::OffSportHi: hdr_d.sport = {byte_i, 8'h00};
        tfapf_pkg::OffSportLo: hdr_d.sport = {hdr_q.sport[15:8], byte_i};
        tfapf_pkg::OffDportHi: hdr_d.dport = {byte_i, 8'h00};
        tfapf_pkg::OffDportLo: hdr_d.dport = {hdr_q.dport[15:8], byte_i};
        tfapf_pkg::OffDataOff: hdr_d.thw = nib_hi[7:4];
        default: ;
      endcase
    end

    if (pos != tfapf_pkg::PosMax) hdr_d.len = pos + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        hdr_q <= '0;
      end else begin
        hdr_q <= hdr_d;
      end
    end
  end

  assign hdr_o = hdr_d;

endmodule

// ----- rtl/core/tfapf_judge.sv -----
// ----------------------------------------------------------------------------
// tfapf_judge
// Frame verdict: length checks, EtherType/protocol checks, empty payload
// check and the address/port filter lookup.
// ----------------------------------------------------------------------------
module tfapf_judge (
  input  tfapf_pkg::hdr_t       hdr_i,
  input  tfapf_pkg::entry_arr_t entries_i,
  output tfapf_pkg::reason_e    reason_o
);

  logic [tfapf_pkg::TcpStartW-1:0] tcp_start, need_raw, need, hdr_sum;
  logic [tfapf_pkg::PosW-1:0]      need_w;
  logic                            hit;

  always_comb begin
    hit = 1'b0;
    for (int unsigned k = 0; k < tfapf_pkg::FilterEntries; k++) begin
      if (entries_i[k].vld &&
          (entries_i[k].port == hdr_i.sport || entries_i[k].port == hdr_i.dport) &&
          (entries_i[k].addr == hdr_i.saddr || entries_i[k].addr == hdr_i.daddr)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    tcp_start = tfapf_pkg::EthHdrLen + {1'b0, hdr_i.ihl, 2'b00};
    need_raw  = tcp_start + tfapf_pkg::TcpHdrMin;
    need      = (need_raw < tfapf_pkg::MinNeed) ? tfapf_pkg::MinNeed : need_raw;
    need_w    = {{(tfapf_pkg::PosW-tfapf_pkg::TcpStartW){1'b0}}, need};
    hdr_sum   = {1'b0, hdr_i.ihl, 2'b00} + {1'b0, hdr_i.thw, 2'b00};

    if (hdr_i.len < tfapf_pkg::LenEth) begin
      reason_o = tfapf_pkg::RsnTrunc;
    end else if (hdr_i.ether_type != tfapf_pkg::EtherTypeIpv4) begin
      reason_o = tfapf_pkg::RsnNotIpv4;
    end else if (hdr_i.len < tfapf_pkg::LenProto) begin
      reason_o = tfapf_pkg::RsnTrunc;
    end else if (hdr_i.proto != tfapf_pkg::ProtoTcp) begin
      reason_o = tfapf_pkg::RsnNotTcp;
    end else if (hdr_i.len < need_w) begin
      reason_o = tfapf_pkg::RsnTrunc;
    end else if (hdr_i.total_len == {9'd0, hdr_sum}) begin
      reason_o = tfapf_pkg::RsnEmpty;
    end else if (!hit) begin
      reason_o = tfapf_pkg::RsnNoHit;
    end else begin
      reason_o = tfapf_pkg::RsnMatch;
    end
  end

endmodule

// ----- rtl/core/tcp_frame_address_port_filter_core.sv -----
// ----------------------------------------------------------------------------
// tcp_frame_address_port_filter_core
// Ethernet/IPv4/TCP header filter: captures header fields from a byte
// stream and gives one verdict per frame on its final byte.
// An accepted final byte passes the input register, then the result register, to its result word.
// Throughput: one byte word per cycle; the input register and result
// register decouple the two sides, only a final byte waits on a full result.
// Reset: asynchronous, clears the filter table, counters and valid flags.
// ----------------------------------------------------------------------------
module tcp_frame_address_port_filter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      frame_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            matched_o,
  output logic [2:0]                      reason_o,
  input  logic                            cfg_we_i,
  input  logic [tfapf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tfapf_pkg::EntryW-1:0]    cfg_data_i
);

  tfapf_pkg::entry_arr_t entries_q;
  tfapf_pkg::hdr_t       hdr;
  tfapf_pkg::reason_e    reason;

  logic       in_valid_q, last_q;
  logic [7:0] byte_q;
  logic       out_valid_q, matched_q;
  logic [2:0] reason_q;
  logic       step;

  assign step       = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_we_i &&
                 ({28'd0, cfg_idx_i} < tfapf_pkg::NumRegs)) begin
      entries_q[cfg_idx_i[$clog2(tfapf_pkg::NumRegs)-1:0]] <= tfapf_pkg::entry_t'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      byte_q <= frame_byte_i;
      last_q <= last_byte_i;
    end
  end

  tfapf_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .last_i (last_q),
    .hdr_o  (hdr)
  );

  tfapf_judge u_judge (
    .hdr_i     (hdr),
    .entries_i (entries_q),
    .reason_o  (reason)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      matched_q <= (reason == tfapf_pkg::RsnMatch);
      reason_q  <= reason;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign reason_o    = reason_q;

endmodule

// ----- tb/tb_tcp_frame_address_port_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_tcp_frame_address_port_filter_core
// Streams Ethernet frames byte by byte into the header filter and checks the
// verdict of every frame against a predictor that captures the same header
// fields. Directed frames cover each reason code and small and large IP
// header lengths. Random frames follow under several filter tables. Both
// sides idle at random, and one long output hold-off backs the block up into
// its input.
// ----------------------------------------------------------------------------
module tb_tcp_frame_address_port_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HostA       = 32'hC0A8_0001;
  localparam logic [15:0] PortA       = 16'd80;
  localparam logic [31:0] HostOff     = 32'h0A00_0002;
  localparam logic [15:0] PortOff     = 16'd443;
  localparam logic [31:0] HostUnused  = 32'h0102_0304;
  localparam logic [15:0] PortUnused  = 16'd22;
  localparam int          UnusedIdxLo = 9;
  localparam int          UnusedIdxHi = 15;
  localparam int          HoldCycles  = 400;

  typedef struct {
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  doff;
    int          len;
  } frame_spec_t;

  // Mirrors the filter table and the per-frame header capture; one verdict
  // is queued for every final byte.
  class verdict_board;
    typedef struct {
      bit                 hit;
      tfapf_pkg::reason_e why;
    } verdict_t;

    tfapf_pkg::entry_t          entries [tfapf_pkg::NumRegs];
    logic [tfapf_pkg::PosW-1:0] pos;
    logic [15:0]                eth_type, tot_len, sport, dport;
    logic [3:0]                 ihl, thw;
    logic [7:0]                 proto;
    logic [31:0]                saddr, daddr;
    verdict_t                   pending [$];
    int                         errors, judged, passed;
    int                         why_count [8];

    function new();
      foreach (entries[k]) entries[k] = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos      = '0;
      eth_type = '0;
      ihl      = '0;
      tot_len  = '0;
      proto    = '0;
      saddr    = '0;
      daddr    = '0;
      sport    = '0;
      dport    = '0;
      thw      = '0;
    endfunction

    function void set_entry(int idx, logic [tfapf_pkg::EntryW-1:0] v);
      if (idx >= 0 && idx < tfapf_pkg::NumRegs) entries[idx] = v;
    endfunction

    function bit any_hit();
      for (int k = 0; k < tfapf_pkg::FilterEntries; k++) begin
        if (entries[k].vld &&
            (entries[k].port == sport || entries[k].port == dport) &&
            (entries[k].addr == saddr || entries[k].addr == daddr))
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function tfapf_pkg::reason_e judge();
      int len;
      int need;
      len  = pos;
      need = 14 + 4 * ihl + 20;
      if (need < 34) need = 34;
      if (len < 14) return tfapf_pkg::RsnTrunc;
      if (eth_type != tfapf_pkg::EtherTypeIpv4) return tfapf_pkg::RsnNotIpv4;
      if (len < 24) return tfapf_pkg::RsnTrunc;
      if (proto != tfapf_pkg::ProtoTcp) return tfapf_pkg::RsnNotTcp;
      if (len < need) return tfapf_pkg::RsnTrunc;
      if (int'(tot_len) == 4 * ihl + 4 * thw) return tfapf_pkg::RsnEmpty;
      if (!any_hit()) return tfapf_pkg::RsnNoHit;
      return tfapf_pkg::RsnMatch;
    endfunction

    function void take_byte(logic [7:0] b, logic eof);
      int       p;
      int       ts;
      verdict_t v;
      p = pos;
      if (p == 12) eth_type = {b, 8'h00};
      if (p == 13) eth_type[7:0] = b;
      if (p == 14) ihl = b[3:0];
      if (p == 16) tot_len = {b, 8'h00};
      if (p == 17) tot_len[7:0] = b;
      if (p == 23) proto = b;
      if (p >= 26 && p <= 29) saddr = {saddr[23:0], b};
      if (p >= 30 && p <= 33) daddr = {daddr[23:0], b};
      // a short IP header puts the TCP header over IP fields
      ts = 14 + 4 * ihl;
      if (p >= ts) begin
        case (p - ts)
          0:  sport = {b, 8'h00};
          1:  sport[7:0] = b;
          2:  dport = {b, 8'h00};
          3:  dport[7:0] = b;
          12: thw = b[7:4];
          default: ;
        endcase
      end
      if (pos < tfapf_pkg::PosMax) pos++;
      if (eof) begin
        v.why = judge();
        v.hit = (v.why == tfapf_pkg::RsnMatch);
        pending.push_back(v);
        clear_frame();
      end
    endfunction

    function void check_verdict(logic m, logic [2:0] r);
      verdict_t v;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: verdict with no frame pending: matched=%0b reason=%0d", $time, m, r);
        return;
      end
      v = pending.pop_front();
      judged++;
      if (v.hit) passed++;
      why_count[v.why]++;
      if (m !== v.hit) begin
        errors++;
        $display("%0t: matched expected %0b, actual %0b", $time, v.hit, m);
      end
      if (r !== v.why) begin
        errors++;
        $display("%0t: reason expected %0d, actual %0d", $time, v.why, r);
      end
    endfunction
  endclass

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    frame_byte_i = '0;
  logic                          last_byte_i  = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic                          matched_o;
  logic [2:0]                    reason_o;
  logic                          cfg_we_i     = 1'b0;
  logic [tfapf_pkg::CfgIdxW-1:0] cfg_idx_i    = '0;
  logic [tfapf_pkg::EntryW-1:0]  cfg_data_i   = '0;

  verdict_board board = new();

  int          bytes_sent;
  int          frames_sent;
  bit          quiet;
  bit          hold_request;
  int          hold_left;
  logic [31:0] addr_pool [tfapf_pkg::NumRegs];
  logic [15:0] port_pool [tfapf_pkg::NumRegs];

  always #10 clk_i = ~clk_i;

  tcp_frame_address_port_filter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .matched_o    (matched_o),
    .reason_o     (reason_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_verdict(matched_o, reason_o);
  end

  initial begin : out_stall_ctl
    int run_left;
    bit run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end else if (run_left > 0) begin
        run_left--;
      end else if (!quiet) begin
        run_stall = !run_stall;
        if (!run_stall) run_left = $urandom_range(0, 12);
        else if ($urandom_range(0, 9) < 8) run_left = $urandom_range(0, 2);
        else run_left = $urandom_range(10, 40);
      end
      out_stall_i <= (hold_left > 0) || (run_stall && !quiet);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic frame_spec_t tcp_frame(logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] sp, logic [15:0] dp, int payload);
    frame_spec_t fs;
    fs.etype   = tfapf_pkg::EtherTypeIpv4;
    fs.ihl     = 4'd5;
    fs.doff    = 4'd5;
    fs.tot_len = 16'(40 + payload);
    fs.proto   = tfapf_pkg::ProtoTcp;
    fs.saddr   = sa;
    fs.daddr   = da;
    fs.sport   = sp;
    fs.dport   = dp;
    fs.len     = 54 + payload;
    return fs;
  endfunction

  function automatic frame_spec_t random_spec();
    frame_spec_t fs;
    int          kind;
    int          payload;
    int          need;
    int          k;
    fs.etype   = tfapf_pkg::EtherTypeIpv4;
    fs.proto   = tfapf_pkg::ProtoTcp;
    fs.ihl     = ($urandom_range(0, 9) < 8) ? 4'd5 : 4'($urandom_range(0, 15));
    fs.doff    = ($urandom_range(0, 9) < 8) ? 4'd5 : 4'($urandom_range(0, 15));
    payload    = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 20);
    fs.tot_len = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                             : 16'(4 * fs.ihl + 4 * fs.doff + payload);
    fs.saddr   = $urandom;
    fs.daddr   = $urandom;
    fs.sport   = 16'($urandom);
    fs.dport   = 16'($urandom);
    if ($urandom_range(0, 9) < 6) begin
      k = $urandom_range(0, tfapf_pkg::NumRegs - 1);
      if ($urandom_range(0, 1)) fs.saddr = addr_pool[k];
      else fs.daddr = addr_pool[k];
      if ($urandom_range(0, 1)) fs.sport = port_pool[k];
      else fs.dport = port_pool[k];
    end else if ($urandom_range(0, 1)) begin
      fs.saddr = addr_pool[$urandom_range(0, tfapf_pkg::NumRegs - 1)];
      fs.dport = port_pool[$urandom_range(0, tfapf_pkg::NumRegs - 1)];
    end
    need = 14 + 4 * fs.ihl + 20;
    if (need < 34) need = 34;
    fs.len = need + $urandom_range(0, 16);
    kind   = $urandom_range(0, 99);
    if (kind < 12) begin
      fs.len = $urandom_range(1, need - 1);
    end else if (kind < 20) begin
      fs.etype = 16'($urandom);
    end else if (kind < 28) begin
      fs.proto = 8'($urandom);
    end else if (kind < 33) begin
      fs.etype   = 16'($urandom);
      fs.proto   = 8'($urandom);
      fs.ihl     = 4'($urandom);
      fs.doff    = 4'($urandom);
      fs.tot_len = 16'($urandom);
      fs.len     = $urandom_range(1, 80);
    end
    return fs;
  endfunction

  // IP fields first, then TCP fields, which win where the two overlap
  function automatic logic [7:0] field_byte(frame_spec_t fs, int i, logic [7:0] fill);
    logic [7:0] b;
    int         ts;
    b  = fill;
    ts = 14 + 4 * fs.ihl;
    case (i)
      12: b = fs.etype[15:8];
      13: b = fs.etype[7:0];
      14: b = {fill[7:4], fs.ihl};
      16: b = fs.tot_len[15:8];
      17: b = fs.tot_len[7:0];
      23: b = fs.proto;
      26: b = fs.saddr[31:24];
      27: b = fs.saddr[23:16];
      28: b = fs.saddr[15:8];
      29: b = fs.saddr[7:0];
      30: b = fs.daddr[31:24];
      31: b = fs.daddr[23:16];
      32: b = fs.daddr[15:8];
      33: b = fs.daddr[7:0];
      default: ;
    endcase
    if (i >= ts) begin
      case (i - ts)
        0:  b = fs.sport[15:8];
        1:  b = fs.sport[7:0];
        2:  b = fs.dport[15:8];
        3:  b = fs.dport[7:0];
        12: b = {fs.doff, fill[3:0]};
        default: ;
      endcase
    end
    return b;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(logic [7:0] b, logic eof);
    int gap;
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= eof;
    do @(posedge clk_i); while (in_stall_o);
    board.take_byte(b, eof);
    bytes_sent++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(frame_spec_t fs);
    for (int i = 0; i < fs.len; i++) push_byte(field_byte(fs, i, 8'($urandom)), i == fs.len - 1);
    frames_sent++;
  endtask

  task automatic write_entry(int idx, logic [tfapf_pkg::EntryW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= (tfapf_pkg::CfgIdxW)'(idx);
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    board.set_entry(idx, v);
    if (idx < tfapf_pkg::NumRegs) begin
      addr_pool[idx] = v[47:16];
      port_pool[idx] = v[15:0];
    end
  endtask

  task automatic write_random_table();
    for (int k = 0; k < tfapf_pkg::NumRegs; k++)
      write_entry(k, {1'($urandom_range(0, 3) != 0), 32'($urandom), 16'($urandom)});
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_random(int min_bytes, int min_frames);
    int b0;
    int f0;
    b0 = bytes_sent;
    f0 = frames_sent;
    while (bytes_sent - b0 < min_bytes || frames_sent - f0 < min_frames)
      send_frame(random_spec());
  endtask

  initial begin : stimulus
    frame_spec_t fs;
    foreach (addr_pool[k]) begin
      addr_pool[k] = '0;
      port_pool[k] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // empty table: truncation points, wrong type, wrong protocol, no hit
    fs = tcp_frame(HostA, HostA, PortA, PortA, 4);
    fs.len = 1;
    send_frame(fs);
    fs.len = 13;
    send_frame(fs);
    fs.len = 14;
    send_frame(fs);
    fs.len = 23;
    send_frame(fs);
    fs.len = 53;
    send_frame(fs);
    fs = tcp_frame(HostA, HostA, PortA, PortA, 4);
    fs.etype = 16'hFFFF;
    fs.len   = 20;
    send_frame(fs);
    fs.etype = 16'h0000;
    send_frame(fs);
    fs = tcp_frame(HostA, HostA, PortA, PortA, 4);
    fs.proto = 8'hFF;
    fs.len   = 24;
    send_frame(fs);
    fs.proto = 8'h00;
    fs.len   = 34;
    send_frame(fs);
    send_frame(tcp_frame(HostA, HostA, PortA, PortA, 4));

    settle();
    write_entry(0, {1'b1, HostA, PortA});
    write_entry(1, '0 | {1'b1, 48'h0});
    write_entry(2, {1'b0, HostOff, PortOff});
    for (int k = 3; k < tfapf_pkg::NumRegs - 1; k++)
      write_entry(k, {1'b1, 32'($urandom), 16'($urandom)});
    write_entry(tfapf_pkg::NumRegs - 1, '1);
    write_entry(UnusedIdxLo, {1'b1, HostUnused, PortUnused});
    write_entry(UnusedIdxHi, {1'b1, HostUnused, PortUnused});

    send_frame(tcp_frame(HostA, 32'h1234_5678, PortA, 16'h1234, 3));
    send_frame(tcp_frame(32'h1234_5678, HostA, 16'h1234, PortA, 3));
    send_frame(tcp_frame(HostA, 32'h1234_5678, 16'h1234, PortA, 3));
    send_frame(tcp_frame(32'hFFFF_FFFF, 32'h1234_5678, 16'hFFFF, 16'h1234, 3));
    send_frame(tcp_frame(32'h0, 32'h1234_5678, 16'h0, 16'h1234, 3));
    send_frame(tcp_frame(HostA, 32'h1234_5678, PortOff, 16'h1234, 3));
    send_frame(tcp_frame(HostOff, 32'h1234_5678, PortOff, 16'h1234, 3));
    send_frame(tcp_frame(HostUnused, 32'h1234_5678, PortUnused, 16'h1234, 3));
    send_frame(tcp_frame(HostA, 32'h1234_5678, PortA, 16'h1234, 0));
    fs = tcp_frame(HostA, 32'h1234_5678, PortA, 16'h1234, 3);
    fs.tot_len = 16'd10;
    send_frame(fs);
    // IHL 0: TCP header starts right after the Ethernet header
    fs = tcp_frame(32'h5555_AAAA, HostA, PortA, 16'h9999, 8);
    fs.ihl     = 4'd0;
    fs.tot_len = 16'd28;
    fs.len     = 42;
    send_frame(fs);
    // IHL 2: source port low byte doubles as the protocol byte
    fs = tcp_frame(32'h5555_AAAA, HostA, 16'h1206, PortA, 4);
    fs.ihl     = 4'd2;
    fs.tot_len = 16'd32;
    fs.len     = 46;
    send_frame(fs);
    fs = tcp_frame(HostA, 32'h1234_5678, PortA, 16'h1234, 5);
    fs.ihl     = 4'd15;
    fs.doff    = 4'd15;
    fs.tot_len = 16'd125;
    fs.len     = 99;
    send_frame(fs);

    settle();
    write_random_table();
    run_random(0, 2);

    settle();
    for (int k = 0; k < tfapf_pkg::NumRegs; k++) write_entry(k, '1);
    run_random(0, 2);

    settle();
    for (int k = 0; k < tfapf_pkg::NumRegs; k++) write_entry(k, '0);
    quiet = 1'b1;
    run_random(0, 2);

    settle();
    quiet = 1'b0;
    write_random_table();
    hold_request = 1'b1;
    run_random(0, 3);

    in_valid_i <= 1'b0;
    for (int w = 0; w < 20000 && board.pending.size() != 0; w++) @(negedge clk_i);
    if (board.pending.size() != 0) begin
      board.errors++;
      $display("%0t: %0d verdicts never arrived", $time, board.pending.size());
    end
    repeat (10) @(negedge clk_i);

    $display("Streamed %0d bytes in %0d frames over six filter tables, with a %0d-cycle hold.",
             bytes_sent, frames_sent, HoldCycles);
    $display("Verdicts: %0d matched; not IPv4 %0d, not TCP %0d, empty %0d, no hit %0d, short %0d.",
             board.why_count[tfapf_pkg::RsnMatch], board.why_count[tfapf_pkg::RsnNotIpv4],
             board.why_count[tfapf_pkg::RsnNotTcp], board.why_count[tfapf_pkg::RsnEmpty],
             board.why_count[tfapf_pkg::RsnNoHit], board.why_count[tfapf_pkg::RsnTrunc]);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
